// ===== rtl/pe_base_relocation_patcher_defines.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef PE_BASE_RELOCATION_PATCHER_DEFINES_SVH
`define PE_BASE_RELOCATION_PATCHER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PBR_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define PBR_ASSERT(label, prop, msg) \
  `PBR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/pbr_pkg.sv =====
`default_nettype none

package pbr_pkg;

  localparam int MAX_SECTIONS = 16;

  localparam int ADDR_W   = 32;
  localparam int DELTA_W  = 64;
  localparam int COUNT_W  = 5;
  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 2;
  localparam int ENTRY_W  = 16;
  localparam int OFS_W    = 12;
  localparam int TYPE_W   = ENTRY_W - OFS_W;
  localparam int PWIDTH_W = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 184;
  localparam int IN_USER_W  = KIND_W;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 1 + STATUS_W;

  localparam logic [ADDR_W-1:0] MIN_BLOCK  = ADDR_W'(8);
  localparam logic [ADDR_W:0]   PATCH_SPAN = (ADDR_W+1)'(8);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SECTION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BLOCK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  // relocation entry types
  localparam logic [TYPE_W-1:0] RT_ABSOLUTE = 4'd0;
  localparam logic [TYPE_W-1:0] RT_HIGH     = 4'd1;
  localparam logic [TYPE_W-1:0] RT_LOW      = 4'd2;
  localparam logic [TYPE_W-1:0] RT_HIGHLOW  = 4'd3;
  localparam logic [TYPE_W-1:0] RT_DIR64    = 4'd10;

  // patch widths
  localparam logic [PWIDTH_W-1:0] PW_NONE = 2'd0;
  localparam logic [PWIDTH_W-1:0] PW_16   = 2'd1;
  localparam logic [PWIDTH_W-1:0] PW_32   = 2'd2;
  localparam logic [PWIDTH_W-1:0] PW_64   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_LOADED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BLOCK  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_PATCH  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_PAD    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_BOUNDS = 3'd4;
  localparam logic [STATUS_W-1:0] STS_UNSUP  = 3'd5;
  localparam logic [STATUS_W-1:0] STS_BADBLK = 3'd6;
  localparam logic [STATUS_W-1:0] STS_HALTED = 3'd7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // lookup token walking the section cell row
  typedef struct packed {
    logic               vld;
    logic [ADDR_W-1:0]  rva;
    logic [COUNT_W-1:0] remain;
    logic               hit;
    logic [ADDR_W-1:0]  fo;
  } qry_t;

  typedef struct packed {
    logic                pvalid;
    logic [ADDR_W-1:0]   offset;
    logic [PWIDTH_W-1:0] pwidth;
    logic [DELTA_W-1:0]  addend;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/pbr_cell.sv =====
`default_nettype none

module pbr_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_en_i,
  input  wire logic [pbr_pkg::ADDR_W-1:0] load_rva_i,
  input  wire logic [pbr_pkg::ADDR_W-1:0] load_size_i,
  input  wire logic [pbr_pkg::ADDR_W-1:0] load_raw_i,
  input  wire pbr_pkg::qry_t             q_i,
  output pbr_pkg::qry_t                  q_o
);

  logic [pbr_pkg::ADDR_W-1:0] start_q, end_q, base_q;
  pbr_pkg::qry_t              q_d, dat_q;
  logic                       vld_q;
  logic                       active, match;

  // keep the end and the raw-minus-start bias so the lookup needs one add
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      start_q <= load_rva_i;
      end_q   <= load_rva_i + load_size_i;
      base_q  <= load_raw_i - load_rva_i;
    end
  end

  always_comb begin
    active = (q_i.remain != '0);
    match  = q_i.vld && !q_i.hit && active &&
             (q_i.rva >= start_q) && (q_i.rva < end_q);
    q_d        = q_i;
    q_d.remain = active ? q_i.remain - pbr_pkg::COUNT_W'(1) : '0;
    q_d.hit    = q_i.hit | match;
    q_d.fo     = match ? base_q + q_i.rva : q_i.fo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= q_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= q_d;
  end

  always_comb begin
    q_o     = dat_q;
    q_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// ===== rtl/pe_base_relocation_patcher.sv =====
// PE base relocation patcher.
// Input stream: s_axis carries one item (section load, block header or relocation
// entry, selected by tuser). Output stream: m_axis returns exactly one result item
// per input item, a patch command or a status only.
// Configuration: cfg_we_i writes register cfg_idx_i (0 delta, 1 image size,
// 2 section count) from cfg_data_i; write only while the block is idle.
// Result path: section loads, block headers, padding, halted and unknown-kind
// items give their result in the cycle after acceptance. An entry that needs an
// address lookup passes the launch register, walks the row of MAX_SECTIONS
// section cells, one cell per cycle, and then fills the result register.
// Throughput: one item in flight; a new item is accepted once the result
// register is empty or being taken, so short items run at one per cycle; a
// lookup entry holds off the next item until its result is registered.
// Stall: a result waits in the output register while m_axis_tready is low, and
// no further item is accepted until it is taken.
// Reset: clears the configuration registers, the page, the halt flag and all handshakes;
// section slots hold no defined value until loaded.
`default_nettype none
`include "pe_base_relocation_patcher_defines.svh"

module pe_base_relocation_patcher (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pbr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pbr_pkg::DELTA_W-1:0]      cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // section_index, section_rva, section_virtual_size, section_raw_offset,
  // page_rva, block_size, entry_word, zero fill
  input  wire logic [pbr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind
  input  wire logic [pbr_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // patch_offset, patch_width, patch_addend, zero fill
  output logic [pbr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // patch_valid, status
  output logic [pbr_pkg::OUT_USER_W-1:0]        m_axis_tuser
);

  localparam int AW = pbr_pkg::ADDR_W;

  // input fields
  logic [pbr_pkg::KIND_W-1:0]  in_kind;
  logic [pbr_pkg::SLOT_W-1:0]  in_slot;
  logic [AW-1:0]               in_srva, in_ssize, in_sraw, in_page, in_bsize;
  logic [pbr_pkg::ENTRY_W-1:0] in_entry;

  assign in_kind  = s_axis_tuser;
  assign in_slot  = s_axis_tdata[3:0];
  assign in_srva  = s_axis_tdata[35:4];
  assign in_ssize = s_axis_tdata[67:36];
  assign in_sraw  = s_axis_tdata[99:68];
  assign in_page  = s_axis_tdata[131:100];
  assign in_bsize = s_axis_tdata[163:132];
  assign in_entry = s_axis_tdata[179:164];

  // configuration registers
  logic [pbr_pkg::DELTA_W-1:0] delta_q;
  logic [AW-1:0]               isize_q;
  logic [pbr_pkg::COUNT_W-1:0] scount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q  <= '0;
      isize_q  <= '0;
      scount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pbr_pkg::CFG_DELTA: delta_q  <= cfg_data_i;
        pbr_pkg::CFG_ISIZE: isize_q  <= cfg_data_i[AW-1:0];
        pbr_pkg::CFG_COUNT: scount_q <= cfg_data_i[pbr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  pbr_pkg::state_e             state_q, state_d;
  logic                        halt_q, halt_d;
  logic [AW-1:0]               page_q, page_d;
  logic [pbr_pkg::TYPE_W-1:0]  typ_q, typ_d;
  pbr_pkg::qry_t               launch_q, launch_d, launch_dat_q;
  logic                        launch_vld_q;
  logic                        out_vld_q, out_vld_d;
  pbr_pkg::res_t               res_q, res_d;

  pbr_pkg::qry_t               chain [0:pbr_pkg::MAX_SECTIONS];
  logic [pbr_pkg::MAX_SECTIONS:0] chain_vld;

  logic                        in_acc, out_take, load_go;
  logic [pbr_pkg::TYPE_W-1:0]  in_type;
  logic [AW-1:0]               fo;
  logic                        oob;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_take = out_vld_q && m_axis_tready;
  assign in_type  = in_entry[pbr_pkg::ENTRY_W-1:pbr_pkg::OFS_W];

  always_comb begin
    launch_q     = launch_dat_q;
    launch_q.vld = launch_vld_q;
  end

  always_comb begin
    state_d       = state_q;
    halt_d        = halt_q;
    page_d        = page_q;
    typ_d         = typ_q;
    launch_d      = launch_q;
    launch_d.vld  = 1'b0;
    out_vld_d     = out_vld_q && !out_take;
    res_d         = res_q;
    s_axis_tready = 1'b0;
    load_go       = 1'b0;
    fo            = chain[pbr_pkg::MAX_SECTIONS].hit ? chain[pbr_pkg::MAX_SECTIONS].fo : '0;
    oob           = (fo == '0) ||
                    (({1'b0, fo} + pbr_pkg::PATCH_SPAN) > {1'b0, isize_q});

    case (state_q)
      pbr_pkg::ST_IDLE: begin
        s_axis_tready = !out_vld_q || m_axis_tready;
        if (in_acc) begin
          res_d        = '0;
          res_d.status = pbr_pkg::STS_UNSUP;
          out_vld_d    = 1'b1;
          case (in_kind)
            pbr_pkg::KIND_SECTION: begin
              load_go      = 1'b1;
              res_d.status = pbr_pkg::STS_LOADED;
              if (in_slot == '0) begin
                halt_d = 1'b0;
              end
            end
            pbr_pkg::KIND_BLOCK: begin
              if (halt_q) begin
                res_d.status = pbr_pkg::STS_HALTED;
              end else if (in_bsize < pbr_pkg::MIN_BLOCK) begin
                halt_d       = 1'b1;
                res_d.status = pbr_pkg::STS_BADBLK;
              end else begin
                page_d       = in_page;
                res_d.status = pbr_pkg::STS_BLOCK;
              end
            end
            pbr_pkg::KIND_ENTRY: begin
              if (halt_q) begin
                res_d.status = pbr_pkg::STS_HALTED;
              end else if (in_type == pbr_pkg::RT_ABSOLUTE) begin
                res_d.status = pbr_pkg::STS_PAD;
              end else begin
                // hand the lookup to the cell row, result comes later
                out_vld_d       = out_vld_q && !out_take;
                typ_d           = in_type;
                launch_d.vld    = 1'b1;
                launch_d.rva    = page_q + AW'(in_entry[pbr_pkg::OFS_W-1:0]);
                launch_d.remain = scount_q;
                launch_d.hit    = 1'b0;
                launch_d.fo     = '0;
                state_d         = pbr_pkg::ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      pbr_pkg::ST_SEARCH: begin
        if (chain[pbr_pkg::MAX_SECTIONS].vld) begin
          res_d        = '0;
          res_d.status = pbr_pkg::STS_UNSUP;
          out_vld_d    = 1'b1;
          state_d      = pbr_pkg::ST_IDLE;
          if (oob) begin
            res_d.status = pbr_pkg::STS_BOUNDS;
          end else begin
            case (typ_q)
              pbr_pkg::RT_DIR64: begin
                res_d.pwidth = pbr_pkg::PW_64;
                res_d.addend = delta_q;
              end
              pbr_pkg::RT_HIGHLOW: begin
                res_d.pwidth = pbr_pkg::PW_32;
                res_d.addend = {32'b0, delta_q[31:0]};
              end
              pbr_pkg::RT_HIGH: begin
                res_d.pwidth = pbr_pkg::PW_16;
                res_d.addend = {48'b0, delta_q[31:16]};
              end
              pbr_pkg::RT_LOW: begin
                res_d.pwidth = pbr_pkg::PW_16;
                res_d.addend = {48'b0, delta_q[15:0]};
              end
              default: ;
            endcase
            if (res_d.pwidth != pbr_pkg::PW_NONE) begin
              res_d.pvalid = 1'b1;
              res_d.offset = fo;
              res_d.status = pbr_pkg::STS_PATCH;
            end
          end
        end
      end
      default: begin
        state_d = pbr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pbr_pkg::ST_IDLE;
      halt_q       <= 1'b0;
      page_q       <= '0;
      out_vld_q    <= 1'b0;
      launch_vld_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      halt_q       <= halt_d;
      page_q       <= page_d;
      out_vld_q    <= out_vld_d;
      launch_vld_q <= launch_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    typ_q        <= typ_d;
    res_q        <= res_d;
    launch_dat_q <= launch_d;
  end

  // section cell row
  assign chain[0]     = launch_q;
  assign chain_vld[0] = launch_q.vld;

  for (genvar i = 0; i < pbr_pkg::MAX_SECTIONS; i++) begin : g_cell
    logic load_en;
    assign load_en = load_go && (32'(in_slot) == i);

    pbr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_en_i  (load_en),
      .load_rva_i (in_srva),
      .load_size_i(in_ssize),
      .load_raw_i (in_sraw),
      .q_i        (chain[i]),
      .q_o        (chain[i+1])
    );

    assign chain_vld[i+1] = chain[i+1].vld;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, res_q.addend, res_q.pwidth, res_q.offset};
  assign m_axis_tuser  = {res_q.status, res_q.pvalid};

  `PBR_ASSERT(a_one_token, $onehot0(chain_vld), "more than one lookup in the cell row")
  `PBR_ASSERT(a_token_in_search, chain_vld[pbr_pkg::MAX_SECTIONS] |-> state_q == pbr_pkg::ST_SEARCH, "lookup finished outside search")
  `PBR_ASSERT(a_no_accept_search, state_q == pbr_pkg::ST_SEARCH |-> !s_axis_tready, "item accepted during lookup")
  `PBR_ASSERT(a_patch_status, out_vld_q && res_q.pvalid |-> res_q.status == pbr_pkg::STS_PATCH && res_q.pwidth != pbr_pkg::PW_NONE, "patch flag without patch status")

endmodule

`default_nettype wire

// ===== dv/tb_pe_base_relocation_patcher.sv =====
`timescale 1ns / 100ps

module tb_pe_base_relocation_patcher;
  import pbr_pkg::*;

  // tdata field positions, input side
  localparam int SIDX_LSB  = 0;
  localparam int SRVA_LSB  = 4;
  localparam int SLEN_LSB  = 36;
  localparam int SRAW_LSB  = 68;
  localparam int PAGE_LSB  = 100;
  localparam int BSIZE_LSB = 132;
  localparam int WORD_LSB  = 164;
  // tdata field positions, result side
  localparam int POFS_LSB  = 0;
  localparam int PW_LSB    = 32;
  localparam int ADD_LSB   = 34;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic                pvalid;
    logic [ADDR_W-1:0]   offset;
    logic [PWIDTH_W-1:0] pwidth;
    logic [DELTA_W-1:0]  addend;
    logic [STATUS_W-1:0] status;
  } patch_cmd_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [DELTA_W-1:0]    cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // predictor copy of the block's registers and state
  logic [DELTA_W-1:0] delta_m = '0;
  logic [ADDR_W-1:0]  isize_m = '0;
  logic [COUNT_W-1:0] sect_cnt_m = '0;
  logic [ADDR_W-1:0]  sect_base_tbl [MAX_SECTIONS];
  logic [ADDR_W-1:0]  sect_len_tbl [MAX_SECTIONS];
  logic [ADDR_W-1:0]  sect_raw_tbl [MAX_SECTIONS];
  logic [ADDR_W-1:0]  page_m = '0;
  logic               halt_m = 1'b0;

  patch_cmd_t patch_cmd_q [$];
  int         mismatch_cnt = 0;
  int         items_sent = 0;
  int         next_gap = 0;
  int         send_gap_max = 9;
  int         take_gap_max = 9;
  logic [ADDR_W-1:0] layout_base = '0;

  pe_base_relocation_patcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lowest-numbered section slot that holds the address wins; no hit maps to zero
  function automatic logic [ADDR_W-1:0] section_file_offset(input logic [ADDR_W-1:0] rva);
    int                n;
    logic [ADDR_W-1:0] lim;
    logic [ADDR_W-1:0] fo;
    logic              found;
    n = (sect_cnt_m > MAX_SECTIONS) ? MAX_SECTIONS : int'(sect_cnt_m);
    fo = '0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      lim = sect_base_tbl[i] + sect_len_tbl[i];
      if (!found && rva >= sect_base_tbl[i] && rva < lim) begin
        fo = sect_raw_tbl[i] + (rva - sect_base_tbl[i]);
        found = 1'b1;
      end
    end
    return fo;
  endfunction

  task automatic predict_patch(input logic [KIND_W-1:0] kind,
                               input logic [IN_DATA_W-1:0] d);
    patch_cmd_t          c;
    logic [SLOT_W-1:0]   slot;
    logic [ENTRY_W-1:0]  word;
    logic [TYPE_W-1:0]   rtype;
    logic [ADDR_W-1:0]   fo;
    c = '0;
    c.status = STS_UNSUP;
    case (kind)
      KIND_SECTION: begin
        slot = d[SIDX_LSB +: SLOT_W];
        sect_base_tbl[slot] = d[SRVA_LSB +: ADDR_W];
        sect_len_tbl[slot]  = d[SLEN_LSB +: ADDR_W];
        sect_raw_tbl[slot]  = d[SRAW_LSB +: ADDR_W];
        if (slot == 0) halt_m = 1'b0;
        c.status = STS_LOADED;
      end
      KIND_BLOCK: begin
        if (halt_m) begin
          c.status = STS_HALTED;
        end else if (d[BSIZE_LSB +: ADDR_W] < MIN_BLOCK) begin
          halt_m = 1'b1;
          c.status = STS_BADBLK;
        end else begin
          page_m = d[PAGE_LSB +: ADDR_W];
          c.status = STS_BLOCK;
        end
      end
      KIND_ENTRY: begin
        word  = d[WORD_LSB +: ENTRY_W];
        rtype = word[ENTRY_W-1:OFS_W];
        if (halt_m) begin
          c.status = STS_HALTED;
        end else if (rtype == RT_ABSOLUTE) begin
          c.status = STS_PAD;
        end else begin
          fo = section_file_offset(page_m + ADDR_W'(word[OFS_W-1:0]));
          // bounds take priority over the type check
          if (fo == 0 || ({1'b0, fo} + 33'd8) > {1'b0, isize_m}) begin
            c.status = STS_BOUNDS;
          end else begin
            c.pvalid = 1'b1;
            c.offset = fo;
            c.status = STS_PATCH;
            case (rtype)
              RT_DIR64: begin
                c.pwidth = PW_64;
                c.addend = delta_m;
              end
              RT_HIGHLOW: begin
                c.pwidth = PW_32;
                c.addend = {32'h0, delta_m[31:0]};
              end
              RT_HIGH: begin
                c.pwidth = PW_16;
                c.addend = {48'h0, delta_m[31:16]};
              end
              RT_LOW: begin
                c.pwidth = PW_16;
                c.addend = {48'h0, delta_m[15:0]};
              end
              default: begin
                c = '0;
                c.status = STS_UNSUP;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    patch_cmd_q.insert(patch_cmd_q.size(), c);
  endtask

  // random content in every field; the item's own fields are laid over it
  function automatic logic [IN_DATA_W-1:0] noise_data();
    logic [IN_DATA_W-1:0] d;
    d = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    d[IN_DATA_W-1:WORD_LSB+ENTRY_W] = '0;
    return d;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IN_DATA_W-1:0] data);
    repeat (next_gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_patch(kind, data);
    items_sent++;
    // hold tvalid high when the next item follows at once
    next_gap = $urandom_range(0, send_gap_max);
    if (next_gap != 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic load_section(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] rva,
                              input logic [ADDR_W-1:0] len, input logic [ADDR_W-1:0] raw);
    logic [IN_DATA_W-1:0] d;
    d = noise_data();
    d[SIDX_LSB +: SLOT_W] = slot;
    d[SRVA_LSB +: ADDR_W] = rva;
    d[SLEN_LSB +: ADDR_W] = len;
    d[SRAW_LSB +: ADDR_W] = raw;
    send_item(KIND_SECTION, d);
  endtask

  task automatic send_block(input logic [ADDR_W-1:0] page, input logic [ADDR_W-1:0] bsize);
    logic [IN_DATA_W-1:0] d;
    d = noise_data();
    d[PAGE_LSB +: ADDR_W]  = page;
    d[BSIZE_LSB +: ADDR_W] = bsize;
    send_item(KIND_BLOCK, d);
  endtask

  task automatic send_entry(input logic [ENTRY_W-1:0] word);
    logic [IN_DATA_W-1:0] d;
    d = noise_data();
    d[WORD_LSB +: ENTRY_W] = word;
    send_item(KIND_ENTRY, d);
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic drain();
    if (next_gap == 0) s_axis_tvalid <= 1'b0;
    while (patch_cmd_q.size() != 0) @(posedge clk_i);
    repeat (MAX_SECTIONS + 4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [DELTA_W-1:0] delta, input logic [ADDR_W-1:0] isize,
                          input logic [COUNT_W-1:0] cnt);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DELTA;
    cfg_data_i <= delta;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ISIZE;
    cfg_data_i <= {$urandom, isize};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COUNT;
    cfg_data_i <= {$urandom, 27'($urandom), cnt};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    delta_m    = delta;
    isize_m    = isize;
    sect_cnt_m = cnt;
  endtask

  task automatic fresh_section(input logic [SLOT_W-1:0] slot);
    logic [ADDR_W-1:0] rva;
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] raw;
    rva = layout_base + ADDR_W'(slot) * 32'h3000 + ($urandom_range(0, 3) << 10);
    case ($urandom_range(0, 15))
      0:       len = '0;
      1:       len = $urandom;
      default: len = $urandom_range(32'h400, 32'h4000);
    endcase
    case ($urandom_range(0, 15))
      0:       raw = '0;
      1:       raw = $urandom;
      default: raw = $urandom_range(1, 32'h100) << 9;
    endcase
    load_section(slot, rva, len, raw);
  endtask

  // mostly a page inside a loaded section, sometimes anywhere
  function automatic logic [ADDR_W-1:0] pick_page();
    logic [SLOT_W-1:0] s;
    logic [ADDR_W-1:0] p;
    s = SLOT_W'($urandom_range(0, MAX_SECTIONS - 1));
    if ($urandom_range(0, 3) == 0) return $urandom;
    p = sect_base_tbl[s] + ((sect_len_tbl[s] == 0) ? 32'h0 : $urandom % sect_len_tbl[s]);
    if ($urandom_range(0, 1) == 0) p[OFS_W-1:0] = '0;
    return p;
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_word();
    logic [TYPE_W-1:0] t;
    case ($urandom_range(0, 9))
      0:       t = RT_ABSOLUTE;
      1:       t = TYPE_W'($urandom_range(4, 15));
      2, 3:    t = RT_DIR64;
      4, 5:    t = RT_HIGHLOW;
      6, 7:    t = RT_HIGH;
      default: t = RT_LOW;
    endcase
    return {t, OFS_W'($urandom)};
  endfunction

  task automatic test_directed();
    set_regs(64'hFEDC_BA98_7654_3210, 32'h0001_0000, 5'd2);
    load_section(4'd0, 32'h1000, 32'h2000, 32'h400);
    // overlaps slot 0 at its high end
    load_section(4'd1, 32'h2800, 32'h1000, 32'h8000);
    load_section(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(32'h1000, 32'd8);
    send_entry({RT_DIR64, 12'h010});
    send_entry({RT_HIGHLOW, 12'h020});
    send_entry({RT_HIGH, 12'h030});
    send_entry({RT_LOW, 12'h040});
    send_entry({RT_ABSOLUTE, 12'hFFF});
    send_entry({4'hF, 12'hFFF});
    send_entry({4'h4, 12'h000});
    send_block(32'h3000, 32'hFFFF_FFFF);
    send_entry({RT_DIR64, 12'h100});
    send_entry({RT_HIGHLOW, 12'h900});
    send_item(KIND_NONE, noise_data());
    // page plus offset wraps past the top of the address space
    send_block(32'hFFFF_FFFF, 32'd8);
    send_entry({RT_HIGHLOW, 12'hFFF});
    send_block(32'h1000, 32'd7);
    send_block(32'h1000, 32'd8);
    send_entry({RT_DIR64, 12'h010});
    send_entry({RT_ABSOLUTE, 12'h000});
    load_section(4'd5, 32'h9000, 32'h100, 32'h200);
    send_entry({RT_LOW, 12'h010});
    load_section(4'd0, 32'h1000, 32'h2000, 32'h400);
    send_block(32'h0, 32'h0);
  endtask

  task automatic test_bounds();
    send_gap_max = 0;
    take_gap_max = 0;
    drain();
    set_regs(64'h8000_0000_0000_0000, 32'h0001_0000, 5'd31);
    load_section(4'd0, 32'h1000, 32'h1000, 32'h0);
    for (int i = 1; i < 13; i++)
      load_section(SLOT_W'(i), ADDR_W'(i) << 16, 32'h100, ADDR_W'(i) << 8);
    load_section(4'd13, 32'h000D_0000, 32'h1000, 32'h0000_FFF0);
    load_section(4'd14, 32'h00E0_0000, 32'h1000, 32'hFFFF_FF00);
    // end of this section wraps, so nothing can hit it
    load_section(4'd15, 32'hFFFF_F000, 32'h2000, 32'h10);
    send_block(32'h1000, 32'h10);
    send_entry({RT_DIR64, 12'h000});
    send_entry({RT_HIGH, 12'h004});
    send_block(32'h000D_0000, 32'h10);
    send_entry({RT_HIGHLOW, 12'h008});
    send_entry({RT_LOW, 12'h009});
    send_block(32'h00E0_0000, 32'd8);
    send_entry({RT_DIR64, 12'h200});
    send_block(32'hFFFF_F000, 32'd8);
    send_entry({RT_DIR64, 12'h010});
    drain();
    send_gap_max = 9;
    take_gap_max = 9;
    set_regs(64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 5'd16);
    load_section(4'd12, 32'h000C_0000, 32'h1000, 32'hFFFF_FF00);
    send_block(32'h000C_0000, 32'd8);
    send_entry({RT_DIR64, 12'h0F7});
    send_entry({RT_HIGHLOW, 12'h0F8});
    drain();
    set_regs(64'h0, 32'h0, 5'd0);
    send_block(32'h1000, 32'd8);
    send_entry({RT_DIR64, 12'h004});
    drain();
    set_regs(64'hFFFF_FFFF_FFFF_FFFF, 32'h0010_0000, 5'd1);
    send_entry({RT_HIGH, 12'h004});
  endtask

  task automatic test_random();
    int stop;
    int r;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      send_gap_max = (ph % 4 == 0 || ph % 4 == 3) ? 9 : 0;
      take_gap_max = (ph % 4 == 0 || ph % 4 == 2) ? 9 : 0;
      case (ph)
        0: set_regs(64'hFFFF_FFFF_FFFF_FFFF, 32'h0004_0000, 5'd16);
        1: set_regs(64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 5'd31);
        2: set_regs(64'h7FFF_FFFF_FFFF_FFFF, 32'h0002_0000, 5'd8);
        3: set_regs(64'h0, 32'h0003_0000, 5'd17);
        4: set_regs({$urandom, $urandom}, $urandom, 5'd1);
        default: set_regs({$urandom, $urandom}, $urandom_range(32'h1000, 32'h0010_0000),
                          COUNT_W'($urandom_range(0, 31)));
      endcase
      layout_base = (ph == 5) ? $urandom : ($urandom & 32'h000F_F000);
      for (int i = 0; i < MAX_SECTIONS; i++) fresh_section(SLOT_W'(i));
      stop = items_sent + 165;
      while (items_sent < stop) begin
        r = $urandom_range(0, 99);
        if (halt_m && r < 40) begin
          fresh_section(4'd0);
        end else if (r < 3) begin
          send_item(KIND_NONE, noise_data());
        end else if (r < 6) begin
          fresh_section(SLOT_W'($urandom_range(0, MAX_SECTIONS - 1)));
        end else if (r < 8) begin
          send_block(pick_page(), $urandom_range(0, 7));
        end else if (r < 9) begin
          drain();
        end else begin
          if ($urandom_range(0, 3) == 0)
            send_block(pick_page(), $urandom | 32'h8);
          else
            send_block(pick_page(), $urandom_range(8, 32'h1000));
          repeat ($urandom_range(1, 12)) send_entry(pick_word());
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bounds();
    test_random();
    drain();
    if (mismatch_cnt == 0)
      $display("tb_pe_base_relocation_patcher: done, clean");
    else
      $display("tb_pe_base_relocation_patcher: done, errors");
    $finish;
  end

  initial begin : result_check
    int         gap;
    patch_cmd_t want;
    patch_cmd_t got;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, take_gap_max);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.pvalid = m_axis_tuser[0];
      got.status = m_axis_tuser[STATUS_W:1];
      got.offset = m_axis_tdata[POFS_LSB +: ADDR_W];
      got.pwidth = m_axis_tdata[PW_LSB +: PWIDTH_W];
      got.addend = m_axis_tdata[ADD_LSB +: DELTA_W];
      if (patch_cmd_q.size() == 0) begin
        $error("result item with none expected: status %0d", got.status);
        mismatch_cnt++;
      end else begin
        want = patch_cmd_q.pop_front();
        if (got.pvalid !== want.pvalid) begin
          $error("patch_valid: expected %0d, got %0d", want.pvalid, got.pvalid);
          mismatch_cnt++;
        end
        if (got.offset !== want.offset) begin
          $error("patch_offset: expected %h, got %h", want.offset, got.offset);
          mismatch_cnt++;
        end
        if (got.pwidth !== want.pwidth) begin
          $error("patch_width: expected %0d, got %0d", want.pwidth, got.pwidth);
          mismatch_cnt++;
        end
        if (got.addend !== want.addend) begin
          $error("patch_addend: expected %h, got %h", want.addend, got.addend);
          mismatch_cnt++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_pe_base_relocation_patcher: done, errors");
    $finish;
  end

endmodule
